// ===== hw/rtl/dvs_pkg.sv =====
// ----------------------------------------------------------------------------
// dvs_pkg: shared types and constants for the display viewport scaler
// Field widths, scale mode codes, register indexes and the structs that
// travel between the front end, the divider and the back end.
// ----------------------------------------------------------------------------
package dvs_pkg;

   localparam int SCR_W     = 14;                 // screen dimension
   localparam int GAME_W    = 12;                 // game dimension
   localparam int FRAC_W    = 4;                  // fraction bits of results
   localparam int OUT_W     = SCR_W + FRAC_W;     // result field width
   localparam int PROD_W    = SCR_W + GAME_W;     // screen x game product

   // divider: 18 quotient bits, 12-bit divisor, 30-bit dividend
   localparam int DIV_QW    = OUT_W;
   localparam int DIV_DW    = GAME_W;
   localparam int DIV_NW    = DIV_QW + DIV_DW;
   localparam int DIV_LANES = 3;

   localparam int LANE_ASPECT = 0;                // 16*p / game dim
   localparam int LANE_INT_W  = 1;                // sw / gw
   localparam int LANE_INT_H  = 2;                // sh / gh

   // register stages: front end (2) + divider (DIV_QW + 1) + back end (3)
   localparam int PIPE_LATENCY = DIV_QW + 6;

   localparam int CSR_IDX_W = 2;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type CSR_FIT_MODE      = 2'd0;
   localparam csr_idx_type CSR_NATIVE_WIDTH  = 2'd1;
   localparam csr_idx_type CSR_NATIVE_HEIGHT = 2'd2;

   localparam logic [GAME_W-1:0] NATIVE_WIDTH_RESET  = 12'd320;
   localparam logic [GAME_W-1:0] NATIVE_HEIGHT_RESET = 12'd240;

   typedef enum logic [1:0] {
      MODE_STRETCH = 2'd0,
      MODE_NONE    = 2'd1,
      MODE_ASPECT  = 2'd2,
      MODE_INTEGER = 2'd3
   } mode_type;

   typedef struct packed {
      logic [SCR_W-1:0] fb_width;
      logic [SCR_W-1:0] fb_height;
   } req_type;

   typedef struct packed {
      logic [OUT_W-1:0] view_x;
      logic [OUT_W-1:0] view_y;
      logic [OUT_W-1:0] view_w;
      logic [OUT_W-1:0] view_h;
   } rsp_type;

   typedef struct packed {
      mode_type          fit_mode;
      logic [GAME_W-1:0] native_width;
      logic [GAME_W-1:0] native_height;
   } cfg_type;

   // per-item sideband carried alongside the divider
   typedef struct packed {
      mode_type          mode;
      logic              sel_h;      // screen is wider than game aspect
      logic              fallback;   // integer mode drops to aspect fit
      logic [SCR_W-1:0]  sw;
      logic [SCR_W-1:0]  sh;
      logic [GAME_W-1:0] gw;         // zero already mapped to one
      logic [GAME_W-1:0] gh;
   } tag_type;

   typedef struct packed {
      logic [DIV_NW-1:0] dividend;
      logic [DIV_DW-1:0] divisor;
   } div_opnd_type;

   typedef struct packed {
      logic [DIV_DW-1:0] rem;        // partial remainder, always < dvsr
      logic [DIV_QW-1:0] nq;         // dividend bits left, quotient bits in
      logic [DIV_DW-1:0] dvsr;
   } div_lane_type;

endpackage

// ===== hw/rtl/dvs_front.sv =====
// ----------------------------------------------------------------------------
// dvs_front: input capture and cross products
// Registers the screen size with the game size, forms sw*gh and sh*gw,
// and prepares the three divider operands.
// ----------------------------------------------------------------------------
module dvs_front (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      in_valid,
   input  dvs_pkg::req_type                          in_req,
   input  dvs_pkg::cfg_type                          cfg,
   output logic                                      out_valid,
   output dvs_pkg::tag_type                          out_tag,
   output dvs_pkg::div_opnd_type [dvs_pkg::DIV_LANES-1:0] out_opnd
);
   import dvs_pkg::*;

   logic              s1_valid_ff;
   logic [SCR_W-1:0]  s1_sw_ff;
   logic [SCR_W-1:0]  s1_sh_ff;
   mode_type          s1_mode_ff;
   logic [GAME_W-1:0] s1_gw_ff;
   logic [GAME_W-1:0] s1_gh_ff;
   logic [GAME_W-1:0] gw_eff;
   logic [GAME_W-1:0] gh_eff;

   logic              s2_valid_ff;
   tag_type           s2_tag_in;
   tag_type           s2_tag_ff;
   logic [PROD_W-1:0] p_wh_in;
   logic [PROD_W-1:0] p_hw_in;
   logic [PROD_W-1:0] p_wh_ff;
   logic [PROD_W-1:0] p_hw_ff;
   logic              sel_h;
   logic [PROD_W-1:0] p_sel;

   // zero game size counts as one
   assign gw_eff = (cfg.native_width  == '0) ? GAME_W'(1) : cfg.native_width;
   assign gh_eff = (cfg.native_height == '0) ? GAME_W'(1) : cfg.native_height;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_sw_ff   <= in_req.fb_width;
      s1_sh_ff   <= in_req.fb_height;
      s1_mode_ff <= cfg.fit_mode;
      s1_gw_ff   <= gw_eff;
      s1_gh_ff   <= gh_eff;
   end

   always_comb begin
      s2_tag_in.mode     = s1_mode_ff;
      s2_tag_in.sel_h    = 1'b0;
      s2_tag_in.fallback = (s1_sw_ff < SCR_W'(s1_gw_ff)) || (s1_sh_ff < SCR_W'(s1_gh_ff));
      s2_tag_in.sw       = s1_sw_ff;
      s2_tag_in.sh       = s1_sh_ff;
      s2_tag_in.gw       = s1_gw_ff;
      s2_tag_in.gh       = s1_gh_ff;
      p_wh_in            = PROD_W'(s1_sw_ff) * PROD_W'(s1_gh_ff);
      p_hw_in            = PROD_W'(s1_sh_ff) * PROD_W'(s1_gw_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_tag_ff <= s2_tag_in;
      p_wh_ff   <= p_wh_in;
      p_hw_ff   <= p_hw_in;
   end

   // wider screen: height is full, width is divided out, and vice versa
   always_comb begin
      sel_h         = p_wh_ff > p_hw_ff;
      p_sel         = sel_h ? p_hw_ff : p_wh_ff;
      out_valid     = s2_valid_ff;
      out_tag       = s2_tag_ff;
      out_tag.sel_h = sel_h;

      out_opnd[LANE_ASPECT].dividend = {p_sel, {FRAC_W{1'b0}}};
      out_opnd[LANE_ASPECT].divisor  = sel_h ? s2_tag_ff.gh : s2_tag_ff.gw;
      out_opnd[LANE_INT_W].dividend  = DIV_NW'(s2_tag_ff.sw);
      out_opnd[LANE_INT_W].divisor   = s2_tag_ff.gw;
      out_opnd[LANE_INT_H].dividend  = DIV_NW'(s2_tag_ff.sh);
      out_opnd[LANE_INT_H].divisor   = s2_tag_ff.gh;
   end

endmodule

// ===== hw/rtl/dvs_div.sv =====
// ----------------------------------------------------------------------------
// dvs_div: pipelined restoring divider, three lanes in lockstep
// One quotient bit per stage; operand register plus DIV_QW step stages.
// ----------------------------------------------------------------------------
module dvs_div (
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           in_valid,
   input  dvs_pkg::tag_type                               in_tag,
   input  dvs_pkg::div_opnd_type [dvs_pkg::DIV_LANES-1:0] in_opnd,
   output logic                                           out_valid,
   output dvs_pkg::tag_type                               out_tag,
   output logic [dvs_pkg::DIV_LANES-1:0][dvs_pkg::DIV_QW-1:0] out_quo
);
   import dvs_pkg::*;

   logic                               valid_in [DIV_QW+1];
   logic                               valid_ff [DIV_QW+1];
   tag_type                            tag_in   [DIV_QW+1];
   tag_type                            tag_ff   [DIV_QW+1];
   div_lane_type [DIV_LANES-1:0]       lane_in  [DIV_QW+1];
   div_lane_type [DIV_LANES-1:0]       lane_ff  [DIV_QW+1];

   always_comb begin
      logic [DIV_DW:0] trial;
      logic            qbit;
      trial = '0;
      qbit  = 1'b0;
      valid_in[0] = in_valid;
      tag_in[0]   = in_tag;
      for (int l = 0; l < DIV_LANES; l++) begin
         lane_in[0][l].rem  = in_opnd[l].dividend[DIV_NW-1:DIV_QW];
         lane_in[0][l].nq   = in_opnd[l].dividend[DIV_QW-1:0];
         lane_in[0][l].dvsr = in_opnd[l].divisor;
      end
      for (int s = 0; s < DIV_QW; s++) begin
         valid_in[s+1] = valid_ff[s];
         tag_in[s+1]   = tag_ff[s];
         for (int l = 0; l < DIV_LANES; l++) begin
            trial = {lane_ff[s][l].rem, lane_ff[s][l].nq[DIV_QW-1]};
            qbit  = trial >= {1'b0, lane_ff[s][l].dvsr};
            if (qbit) begin
               lane_in[s+1][l].rem = DIV_DW'(trial - {1'b0, lane_ff[s][l].dvsr});
            end else begin
               lane_in[s+1][l].rem = trial[DIV_DW-1:0];
            end
            lane_in[s+1][l].nq   = {lane_ff[s][l].nq[DIV_QW-2:0], qbit};
            lane_in[s+1][l].dvsr = lane_ff[s][l].dvsr;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s <= DIV_QW; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= valid_in[s];
         end
         tag_ff[s]  <= tag_in[s];
         lane_ff[s] <= lane_in[s];
      end
   end

   always_comb begin
      out_valid = valid_ff[DIV_QW];
      out_tag   = tag_ff[DIV_QW];
      for (int l = 0; l < DIV_LANES; l++) begin
         out_quo[l] = lane_ff[DIV_QW][l].nq;
      end
   end

   // quotient must fit in DIV_QW bits: the leading remainder is below the divisor
   for (genvar l = 0; l < DIV_LANES; l++) begin : g_chk
      a_rem_below_dvsr: assert property (@(posedge clock) disable iff (reset)
         valid_ff[0] |-> (lane_ff[0][l].rem < lane_ff[0][l].dvsr))
         else $error("divider lane %0d: quotient overflows", l);
   end

endmodule

// ===== hw/rtl/dvs_back.sv =====
// ----------------------------------------------------------------------------
// dvs_back: viewport selection and centering
// Integer scale products, per-mode size selection, then centering offsets.
// ----------------------------------------------------------------------------
module dvs_back (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   input  dvs_pkg::tag_type                                   in_tag,
   input  logic [dvs_pkg::DIV_LANES-1:0][dvs_pkg::DIV_QW-1:0] in_quo,
   output logic                                               rsp_valid,
   output dvs_pkg::rsp_type                                   rsp
);
   import dvs_pkg::*;

   // E1: integer scale and products
   logic [SCR_W-1:0]  k_w;
   logic [SCR_W-1:0]  k_h;
   logic [SCR_W-1:0]  k_min;
   logic [PROD_W-1:0] pw_in;
   logic [PROD_W-1:0] ph_in;
   logic              e1_valid_ff;
   tag_type           e1_tag_ff;
   logic [OUT_W-1:0]  e1_aq_ff;
   logic [PROD_W-1:0] e1_pw_ff;
   logic [PROD_W-1:0] e1_ph_ff;

   // E2: chosen size
   logic [OUT_W-1:0]  full_w;
   logic [OUT_W-1:0]  full_h;
   logic [OUT_W-1:0]  asp_w;
   logic [OUT_W-1:0]  asp_h;
   logic [SCR_W-1:0]  none_w;
   logic [SCR_W-1:0]  none_h;
   logic [OUT_W-1:0]  vw_in;
   logic [OUT_W-1:0]  vh_in;
   logic              e2_valid_ff;
   logic [OUT_W-1:0]  e2_vw_ff;
   logic [OUT_W-1:0]  e2_vh_ff;
   logic [OUT_W-1:0]  e2_fw_ff;
   logic [OUT_W-1:0]  e2_fh_ff;

   // E3: output register
   rsp_type           rsp_in;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   always_comb begin
      k_w   = in_quo[LANE_INT_W][SCR_W-1:0];
      k_h   = in_quo[LANE_INT_H][SCR_W-1:0];
      k_min = (k_w < k_h) ? k_w : k_h;
      pw_in = PROD_W'(in_tag.gw) * PROD_W'(k_min);
      ph_in = PROD_W'(in_tag.gh) * PROD_W'(k_min);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else begin
         e1_valid_ff <= in_valid;
      end
      e1_tag_ff <= in_tag;
      e1_aq_ff  <= in_quo[LANE_ASPECT];
      e1_pw_ff  <= pw_in;
      e1_ph_ff  <= ph_in;
   end

   always_comb begin
      full_w = {e1_tag_ff.sw, {FRAC_W{1'b0}}};
      full_h = {e1_tag_ff.sh, {FRAC_W{1'b0}}};
      none_w = (e1_tag_ff.sw < SCR_W'(e1_tag_ff.gw)) ? e1_tag_ff.sw : SCR_W'(e1_tag_ff.gw);
      none_h = (e1_tag_ff.sh < SCR_W'(e1_tag_ff.gh)) ? e1_tag_ff.sh : SCR_W'(e1_tag_ff.gh);
      asp_w  = e1_tag_ff.sel_h ? e1_aq_ff : full_w;
      asp_h  = e1_tag_ff.sel_h ? full_h : e1_aq_ff;
      case (e1_tag_ff.mode)
         MODE_STRETCH: begin
            vw_in = full_w;
            vh_in = full_h;
         end
         MODE_NONE: begin
            vw_in = {none_w, {FRAC_W{1'b0}}};
            vh_in = {none_h, {FRAC_W{1'b0}}};
         end
         MODE_ASPECT: begin
            vw_in = asp_w;
            vh_in = asp_h;
         end
         MODE_INTEGER: begin
            if (e1_tag_ff.fallback) begin
               vw_in = asp_w;
               vh_in = asp_h;
            end else begin
               vw_in = {e1_pw_ff[SCR_W-1:0], {FRAC_W{1'b0}}};
               vh_in = {e1_ph_ff[SCR_W-1:0], {FRAC_W{1'b0}}};
            end
         end
         default: begin
            vw_in = full_w;
            vh_in = full_h;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else begin
         e2_valid_ff <= e1_valid_ff;
      end
      e2_vw_ff <= vw_in;
      e2_vh_ff <= vh_in;
      e2_fw_ff <= full_w;
      e2_fh_ff <= full_h;
   end

   // centering; stretch lands on zero offsets by itself
   always_comb begin
      rsp_in.view_w = e2_vw_ff;
      rsp_in.view_h = e2_vh_ff;
      rsp_in.view_x = (e2_fw_ff - e2_vw_ff) >> 1;
      rsp_in.view_y = (e2_fh_ff - e2_vh_ff) >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= e2_valid_ff;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   a_view_in_screen: assert property (@(posedge clock) disable iff (reset)
      e2_valid_ff |-> ((e2_vw_ff <= e2_fw_ff) && (e2_vh_ff <= e2_fh_ff)))
      else $error("viewport larger than screen");

endmodule

// ===== hw/rtl/display_viewport_scaler.sv =====
// ----------------------------------------------------------------------------
// display_viewport_scaler: centered viewport for a fixed game resolution
// Start transfers run through front end, divider and back end to rsp_valid.
// Throughput: one item per cycle; the divider sets the depth.
// busy is high only while reset is asserted; results cannot be held off.
// Reset clears all pipeline valids and loads the fit mode with aspect fit,
// game size 320x240. Configuration writes are taken every cycle out of reset.
// ----------------------------------------------------------------------------
module display_viewport_scaler (
   input  logic                 clock,
   input  logic                 reset,
   // request
   input  logic                 start,
   output logic                 busy,
   input  dvs_pkg::req_type     req_data,
   // result strobe
   output logic                 rsp_valid,
   output dvs_pkg::rsp_type     rsp_data,
   // register writes
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  dvs_pkg::csr_idx_type csr_index,
   input  logic [dvs_pkg::GAME_W-1:0] csr_wdata
);
   import dvs_pkg::*;

   // configuration registers
   mode_type          fit_mode_ff;
   logic [GAME_W-1:0] native_width_ff;
   logic [GAME_W-1:0] native_height_ff;
   cfg_type           cfg;
   logic              csr_write;

   // stage links
   logic                                 req_accept;
   logic                                 fe_valid;
   tag_type                              fe_tag;
   div_opnd_type [DIV_LANES-1:0]         fe_opnd;
   logic                                 dv_valid;
   tag_type                              dv_tag;
   logic [DIV_LANES-1:0][DIV_QW-1:0]     dv_quo;

   // nothing upstream of the output can stall, so only reset holds off work
   assign busy       = reset;
   assign csr_ready  = ~reset;
   assign req_accept = start && !busy;
   assign csr_write  = csr_valid && csr_ready;

   // register file; indexes past the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff      <= MODE_ASPECT;
         native_width_ff  <= NATIVE_WIDTH_RESET;
         native_height_ff <= NATIVE_HEIGHT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_FIT_MODE:      fit_mode_ff      <= mode_type'(csr_wdata[1:0]);
            CSR_NATIVE_WIDTH:  native_width_ff  <= csr_wdata;
            CSR_NATIVE_HEIGHT: native_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign cfg.fit_mode      = fit_mode_ff;
   assign cfg.native_width  = native_width_ff;
   assign cfg.native_height = native_height_ff;

   // two stages: capture, then the sw*gh / sh*gw cross products
   dvs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_req    (req_data),
      .cfg       (cfg),
      .out_valid (fe_valid),
      .out_tag   (fe_tag),
      .out_opnd  (fe_opnd)
   );

   // aspect quotient plus both integer scale quotients, one bit per stage
   dvs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fe_valid),
      .in_tag    (fe_tag),
      .in_opnd   (fe_opnd),
      .out_valid (dv_valid),
      .out_tag   (dv_tag),
      .out_quo   (dv_quo)
   );

   // three stages: scale products, mode select, centering into rsp register
   dvs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dv_valid),
      .in_tag    (dv_tag),
      .in_quo    (dv_quo),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

   // every strobe traces back to a request accepted at the pipe's entry
   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_accept, PIPE_LATENCY))
      else $error("result strobe without matching request");

   a_gw_write: assert property (@(posedge clock) disable iff (reset)
      (csr_write && (csr_index == CSR_NATIVE_WIDTH)) |=>
         (native_width_ff == $past(csr_wdata)))
      else $error("game width write lost");

endmodule

// ===== tb/display_viewport_scaler_tb.sv =====
// ----------------------------------------------------------------------------
// display_viewport_scaler_tb: self-checking bench for the viewport scaler
// Sends screen sizes through the start/busy request port under every scale
// mode and a range of game sizes, rewrites the registers between phases with
// the pipe empty, and checks every result strobe against a predictor or a hand-worked value.
// ----------------------------------------------------------------------------
module display_viewport_scaler_tb;
   import dvs_pkg::*;

   localparam int          RANDOM_PHASES   = 18;
   localparam int          ITEMS_PER_PHASE = 80;
   localparam int          WATCHDOG_LIMIT  = 4000;
   localparam int          NUM_DIRECTED    = 23;
   localparam csr_idx_type CSR_UNUSED      = 2'd3;   // not mapped, writes ignored
   localparam rsp_type     NO_VIEW         = '0;

   // One directed row: register setting, screen size, and an optional
   // hand-worked result. Rows with known low use the predictor instead.
   typedef struct packed {
      mode_type          mode;
      logic [GAME_W-1:0] gw;
      logic [GAME_W-1:0] gh;
      logic [SCR_W-1:0]  sw;
      logic [SCR_W-1:0]  sh;
      logic              known;
      rsp_type           view;
   } screen_case_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_data;
   logic                 rsp_valid;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   csr_idx_type          csr_index;
   logic [GAME_W-1:0]    csr_wdata;

   // Sideband that travels with req_data: a typed-in result for this request
   logic                 typed_known;
   rsp_type              typed_view;

   // Shadow of the scaler registers, updated on each csr transfer
   mode_type             model_mode = MODE_ASPECT;
   logic [GAME_W-1:0]    model_gw   = NATIVE_WIDTH_RESET;
   logic [GAME_W-1:0]    model_gh   = NATIVE_HEIGHT_RESET;

   rsp_type              pending_views [$];
   int                   mismatch_count = 0;
   int                   stall_cycles   = 0;

   // The first rows run on the reset setting (aspect fit, 320x240) with no
   // register write in front of them, so they also check the reset values.
   screen_case_type directed_cases [0:NUM_DIRECTED-1] = '{
      // aspect fit, reset game size
      '{MODE_ASPECT,  12'd320,  12'd240,  14'd320,   14'd240,   1'b1,
        '{18'd0, 18'd0, 18'd5120, 18'd3840}},
      '{MODE_ASPECT,  12'd320,  12'd240,  14'd0,     14'd0,     1'b1, NO_VIEW},
      '{MODE_ASPECT,  12'd320,  12'd240,  14'd640,   14'd240,   1'b1,
        '{18'd2560, 18'd0, 18'd5120, 18'd3840}},
      '{MODE_ASPECT,  12'd320,  12'd240,  14'd16383, 14'd16383, 1'b0, NO_VIEW},
      '{MODE_ASPECT,  12'd320,  12'd240,  14'd1,     14'd16383, 1'b0, NO_VIEW},
      // stretch: offsets always zero, size is the whole screen
      '{MODE_STRETCH, 12'd320,  12'd240,  14'd16383, 14'd16383, 1'b1,
        '{18'd0, 18'd0, 18'd262128, 18'd262128}},
      '{MODE_STRETCH, 12'd320,  12'd240,  14'd0,     14'd0,     1'b1, NO_VIEW},
      '{MODE_STRETCH, 12'd320,  12'd240,  14'd1,     14'd16383, 1'b1,
        '{18'd0, 18'd0, 18'd16, 18'd262128}},
      // none: native size clipped per axis
      '{MODE_NONE,    12'd320,  12'd240,  14'd100,   14'd1000,  1'b0, NO_VIEW},
      '{MODE_NONE,    12'd320,  12'd240,  14'd16383, 14'd16383, 1'b0, NO_VIEW},
      '{MODE_NONE,    12'd320,  12'd240,  14'd0,     14'd0,     1'b1, NO_VIEW},
      // integer multiple, with fallback when either axis is below the game
      '{MODE_INTEGER, 12'd320,  12'd240,  14'd320,   14'd240,   1'b1,
        '{18'd0, 18'd0, 18'd5120, 18'd3840}},
      '{MODE_INTEGER, 12'd320,  12'd240,  14'd1920,  14'd1080,  1'b0, NO_VIEW},
      '{MODE_INTEGER, 12'd320,  12'd240,  14'd319,   14'd240,   1'b0, NO_VIEW},
      '{MODE_INTEGER, 12'd320,  12'd240,  14'd640,   14'd239,   1'b0, NO_VIEW},
      '{MODE_INTEGER, 12'd320,  12'd240,  14'd16383, 14'd16383, 1'b0, NO_VIEW},
      '{MODE_INTEGER, 12'd320,  12'd240,  14'd0,     14'd0,     1'b1, NO_VIEW},
      // zero game width acts as one
      '{MODE_ASPECT,  12'd0,    12'd240,  14'd100,   14'd100,   1'b0, NO_VIEW},
      // zero game height acts as one
      '{MODE_INTEGER, 12'd4095, 12'd0,    14'd16383, 14'd16383, 1'b0, NO_VIEW},
      '{MODE_INTEGER, 12'd4095, 12'd4095, 14'd16383, 14'd16383, 1'b0, NO_VIEW},
      '{MODE_INTEGER, 12'd1,    12'd1,    14'd16383, 14'd1,     1'b0, NO_VIEW},
      '{MODE_NONE,    12'd0,    12'd0,    14'd5,     14'd5,     1'b0, NO_VIEW},
      '{MODE_ASPECT,  12'd4095, 12'd1,    14'd16383, 14'd16383, 1'b0, NO_VIEW}
   };

   display_viewport_scaler dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor: viewport for one screen size under the shadow registers.
   // Wide unsigned math, then cut to the 18-bit result fields.
   // ------------------------------------------------------------------------
   function automatic rsp_type predict_view(req_type screen);
      longint unsigned sw, sh, gw, gh, vx, vy, vw, vh, mult;
      rsp_type         view;
      sw = screen.fb_width;
      sh = screen.fb_height;
      gw = (model_gw == '0) ? 1 : model_gw;
      gh = (model_gh == '0) ? 1 : model_gh;
      if (model_mode == MODE_STRETCH) begin
         vx = 0;
         vy = 0;
         vw = sw << FRAC_W;
         vh = sh << FRAC_W;
      end else begin
         if (model_mode == MODE_NONE) begin
            vw = ((sw < gw) ? sw : gw) << FRAC_W;
            vh = ((sh < gh) ? sh : gh) << FRAC_W;
         end else if (model_mode == MODE_ASPECT || sw < gw || sh < gh) begin
            // screen relatively wider than the game: height limits the fit
            if (sw * gh > sh * gw) begin
               vh = sh << FRAC_W;
               vw = ((sh * gw) << FRAC_W) / gh;
            end else begin
               vw = sw << FRAC_W;
               vh = ((sw * gh) << FRAC_W) / gw;
            end
         end else begin
            mult = ((sw / gw) < (sh / gh)) ? (sw / gw) : (sh / gh);
            vw = (gw * mult) << FRAC_W;
            vh = (gh * mult) << FRAC_W;
         end
         // centering uses the already truncated size
         vx = ((sw << FRAC_W) - vw) / 2;
         vy = ((sh << FRAC_W) - vh) / 2;
      end
      view.view_x = vx[OUT_W-1:0];
      view.view_y = vy[OUT_W-1:0];
      view.view_w = vw[OUT_W-1:0];
      view.view_h = vh[OUT_W-1:0];
      return view;
   endfunction

   // Screen dimension biased toward the interesting spots around the game size
   function automatic logic [SCR_W-1:0] random_screen_dim(logic [GAME_W-1:0] game_dim);
      int g;
      int v;
      g = (game_dim == '0) ? 1 : int'(game_dim);
      case ($urandom_range(0, 5))
         1: begin
            v = int'($urandom_range(0, 63));
         end
         2: begin
            // just around a whole multiple of the game size
            v = g * int'($urandom_range(0, 16383 / g)) + int'($urandom_range(0, 2)) - 1;
         end
         3: begin
            case ($urandom_range(0, 3))
               0: v = 0;
               1: v = 1;
               2: v = 16382;
               default: v = 16383;
            endcase
         end
         4: begin
            v = g + int'($urandom_range(0, 4)) - 2;
         end
         default: begin
            v = int'($urandom_range(0, 16383));
         end
      endcase
      if (v < 0) v = 0;
      if (v > 16383) v = 16383;
      return v[SCR_W-1:0];
   endfunction

   function automatic logic [GAME_W-1:0] random_game_dim();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return 12'd1;
         2: return 12'd4095;
         3: return GAME_W'($urandom_range(1, 32));
         default: return GAME_W'($urandom_range(1, 4095));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side. start is left high after a transfer so a following
   // request with no gap goes back to back; wait_drain and a gap lower it.
   // ------------------------------------------------------------------------
   task automatic send_screen(req_type screen, logic known, rsp_type view, int gap);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_data    <= screen;
      typed_known <= known;
      typed_view  <= view;
      // transfer happens at the first edge that sees busy low
      do @(posedge clock); while (busy);
   endtask

   // Hold requests and wait for every outstanding result to come back
   task automatic wait_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_views.size() != 0);
   endtask

   task automatic write_reg(csr_idx_type idx, logic [GAME_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Full register setting; unused mode bits carry random junk
   task automatic set_scaling(mode_type mode, logic [GAME_W-1:0] gw,
                              logic [GAME_W-1:0] gh);
      logic [GAME_W-1:0] mode_word;
      mode_word      = GAME_W'($urandom);
      mode_word[1:0] = mode;
      write_reg(CSR_FIT_MODE, mode_word);
      write_reg(CSR_NATIVE_WIDTH, gw);
      write_reg(CSR_NATIVE_HEIGHT, gh);
   endtask

   task automatic check_field(string name, logic [OUT_W-1:0] expected,
                              logic [OUT_W-1:0] actual);
      if (expected !== actual) begin
         $error("%s: expected %0d, actual %0d", name, expected, actual);
         mismatch_count++;
      end
   endtask

   // ------------------------------------------------------------------------
   // Monitor: all sampling on the rising edge, so every value read here is
   // the one that was stable through the cycle just ended.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         model_mode   = MODE_ASPECT;
         model_gw     = NATIVE_WIDTH_RESET;
         model_gh     = NATIVE_HEIGHT_RESET;
         stall_cycles = 0;
      end else begin
         // result check goes first: a result never belongs to a request
         // transferred at the same edge
         if (rsp_valid) begin
            if (pending_views.size() == 0) begin
               $error("result strobe with no request outstanding");
               mismatch_count++;
            end else begin
               rsp_type expected_view;
               expected_view = pending_views.pop_front();
               check_field("view_x", expected_view.view_x, rsp_data.view_x);
               check_field("view_y", expected_view.view_y, rsp_data.view_y);
               check_field("view_w", expected_view.view_w, rsp_data.view_w);
               check_field("view_h", expected_view.view_h, rsp_data.view_h);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FIT_MODE:      model_mode = mode_type'(csr_wdata[1:0]);
               CSR_NATIVE_WIDTH:  model_gw   = csr_wdata;
               CSR_NATIVE_HEIGHT: model_gh   = csr_wdata;
               default: ;
            endcase
         end
         if (start && !busy)
            pending_views.push_back(typed_known ? typed_view : predict_view(req_data));

         // watchdog: any transfer on any port counts as progress
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin
      screen_case_type row;
      req_type         screen;
      mode_type        mode;
      logic [GAME_W-1:0] gw;
      logic [GAME_W-1:0] gh;
      bit              calm;

      reset       <= 1'b1;
      start       <= 1'b0;
      req_data    <= '0;
      typed_known <= 1'b0;
      typed_view  <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_FIT_MODE;
      csr_wdata   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Directed rows. Registers only change with the pipe empty, which
      // also makes the sender wait out every outstanding result.
      for (int i = 0; i < NUM_DIRECTED; i++) begin
         row = directed_cases[i];
         if (row.mode != model_mode || row.gw != model_gw || row.gh != model_gh) begin
            wait_drain();
            set_scaling(row.mode, row.gw, row.gh);
         end
         screen.fb_width  = row.sw;
         screen.fb_height = row.sh;
         send_screen(screen, row.known, row.view, $urandom_range(0, 15));
      end

      // Random phases, each with its own register setting. Some phases run
      // with no request gaps at all so the pipe stays full.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         wait_drain();
         mode = mode_type'($urandom_range(0, 3));
         gw   = random_game_dim();
         gh   = random_game_dim();
         if ($urandom_range(0, 3) == 0)
            write_reg(CSR_UNUSED, GAME_W'($urandom));
         set_scaling(mode, gw, gh);
         calm = ($urandom_range(0, 3) == 0);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            screen.fb_width  = random_screen_dim(model_gw);
            screen.fb_height = random_screen_dim(model_gh);
            send_screen(screen, 1'b0, NO_VIEW, calm ? 0 : $urandom_range(0, 15));
         end
      end

      // Empty the pipe, then give a stray extra strobe time to show up
      wait_drain();
      repeat (PIPE_LATENCY + 8) @(posedge clock);
      if (mismatch_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
